// ===== rtl/angle_rate_bias_kalman_filter_top_assert.svh =====
// Assertion macros for the angle, rate and bias filter top level.
// Needs signals named clock and reset in the including module.
`ifndef ANGLE_RATE_BIAS_KALMAN_FILTER_TOP_ASSERT_SVH
`define ANGLE_RATE_BIAS_KALMAN_FILTER_TOP_ASSERT_SVH

// Condition in one cycle implies a condition in the same cycle.
`define AKF_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define AKF_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/arbkf_pkg.sv =====
// Shared types, constants and the step sequence of the angle, rate and bias filter.
// No dependencies; the ALU, the divider, the top level and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package arbkf_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int WIDE_BITS = 2 * WORD_BITS + 1;
   localparam int QUOT_BITS = WORD_BITS + 1;
   localparam int MEM_DEPTH = 32;
   localparam int ADDR_BITS = $clog2(MEM_DEPTH);
   localparam int PC_BITS   = 7;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 31;
   localparam int DT_BITS        = 16;
   localparam int NOISE_BITS     = 31;

   typedef logic signed [WORD_BITS-1:0]   word_type;
   typedef logic signed [2*WORD_BITS-1:0] prod_type;
   typedef logic signed [WIDE_BITS-1:0]   wide_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic [PC_BITS-1:0]            pc_type;
   typedef logic [CSR_INDEX_BITS-1:0]     csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]      csr_data_type;

   localparam word_type FIX_ONE  = word_type'(64'sd1 <<< FRAC_BITS);
   localparam word_type FIX_INIT = word_type'(64'sd1000 <<< FRAC_BITS);

   localparam csr_index_type CSR_TIME_STEP   = 3'd0;
   localparam csr_index_type CSR_ANGLE_QNS   = 3'd1;
   localparam csr_index_type CSR_RATE_QNS    = 3'd2;
   localparam csr_index_type CSR_BIAS_QNS    = 3'd3;
   localparam csr_index_type CSR_ANGLE_RNS   = 3'd4;
   localparam csr_index_type CSR_RATE_RNS    = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SINGULAR  = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   typedef struct packed {
      logic signed [31:0] angle_meas;
      logic signed [31:0] rate_meas;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic signed [31:0] angle_est;
      logic signed [31:0] rate_est;
      logic signed [31:0] bias_est;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_MOV, OP_ADD, OP_SUB, OP_FMUL, OP_PSET, OP_PSUB, OP_DET, OP_DIV, OP_DONE
   } op_type;

   typedef enum logic [3:0] {
      BS_MEM, BS_ZERO, BS_ONE, BS_INIT, BS_DT, BS_QA, BS_QR, BS_QB, BS_RA, BS_RR,
      BS_Z1, BS_Z2
   } bsel_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EXEC, ST_WRITE, ST_DIV, ST_OUT
   } state_type;

   typedef struct packed {
      op_type   op;
      addr_type a;
      addr_type b;
      bsel_type bsel;
      addr_type dst;
   } uop_type;

   typedef struct packed {
      logic   exec_en;
      logic   wr_en;
      op_type op;
   } alu_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic sat;
   } div_stat_type;

   // Scratch memory map. The Q entries reuse scratch words that are dead by then.
   localparam addr_type A_X0 = 5'd0, A_X1 = 5'd1, A_X2 = 5'd2;
   localparam addr_type A_P0 = 5'd3, A_P1 = 5'd4, A_P2 = 5'd5;
   localparam addr_type A_P3 = 5'd6, A_P4 = 5'd7, A_P5 = 5'd8;
   localparam addr_type A_P6 = 5'd9, A_P7 = 5'd10, A_P8 = 5'd11;
   localparam addr_type A_ZA = 5'd12, A_ZR = 5'd13, A_T0 = 5'd14, A_T1 = 5'd15;
   localparam addr_type A_TA = 5'd16, A_TB = 5'd17, A_TC = 5'd18;
   localparam addr_type A_Y1 = 5'd19, A_Y2 = 5'd20, A_S11 = 5'd21, A_S22 = 5'd22;
   localparam addr_type A_K11 = 5'd23, A_K12 = 5'd24, A_K21 = 5'd25;
   localparam addr_type A_K22 = 5'd26, A_K31 = 5'd27, A_K32 = 5'd28;
   localparam addr_type A_M11 = 5'd29, A_M22 = 5'd30;
   localparam addr_type A_Q11 = 5'd12, A_Q12 = 5'd13, A_Q13 = 5'd16;
   localparam addr_type A_Q21 = 5'd17, A_Q22 = 5'd18, A_Q23 = 5'd19;
   localparam addr_type A_Q31 = 5'd20, A_Q32 = 5'd21, A_Q33 = 5'd22;

   localparam pc_type INIT_LEN = 7'd12;
   localparam pc_type DONE_PC  = 7'd119;

   function automatic uop_type uo(op_type op, addr_type a, addr_type b, bsel_type bs,
                                  addr_type d);
      uop_type u;
      u.op = op; u.a = a; u.b = b; u.bsel = bs; u.dst = d;
      return u;
   endfunction

   // Register to register operation.
   function automatic uop_type rr(op_type op, addr_type d, addr_type a, addr_type b);
      return uo(op, a, b, BS_MEM, d);
   endfunction

   // Register with a constant or configuration operand.
   function automatic uop_type rk(op_type op, addr_type d, addr_type a, bsel_type bs);
      return uo(op, a, a, bs, d);
   endfunction

   function automatic uop_type ucode(pc_type pc);
      uop_type u;
      u = uo(OP_DONE, A_X0, A_X0, BS_ZERO, A_X0);
      case (int'(pc))
         // Reload of the initial state.
         0:   u = rk(OP_MOV, A_X0, A_X0, BS_ZERO);
         1:   u = rk(OP_MOV, A_X1, A_X1, BS_ZERO);
         2:   u = rk(OP_MOV, A_X2, A_X2, BS_ZERO);
         3:   u = rk(OP_MOV, A_P0, A_P0, BS_INIT);
         4:   u = rk(OP_MOV, A_P1, A_P1, BS_ZERO);
         5:   u = rk(OP_MOV, A_P2, A_P2, BS_ZERO);
         6:   u = rk(OP_MOV, A_P3, A_P3, BS_ZERO);
         7:   u = rk(OP_MOV, A_P4, A_P4, BS_INIT);
         8:   u = rk(OP_MOV, A_P5, A_P5, BS_ZERO);
         9:   u = rk(OP_MOV, A_P6, A_P6, BS_ZERO);
         10:  u = rk(OP_MOV, A_P7, A_P7, BS_ZERO);
         11:  u = rk(OP_MOV, A_P8, A_P8, BS_INIT);
         // Prediction.
         12:  u = rk(OP_MOV, A_ZA, A_ZA, BS_Z1);
         13:  u = rk(OP_MOV, A_ZR, A_ZR, BS_Z2);
         14:  u = rr(OP_SUB, A_T0, A_X1, A_X2);
         15:  u = rk(OP_FMUL, A_T0, A_T0, BS_DT);
         16:  u = rr(OP_ADD, A_X0, A_X0, A_T0);
         17:  u = rr(OP_SUB, A_T0, A_P3, A_P6);
         18:  u = rk(OP_FMUL, A_T0, A_T0, BS_DT);
         19:  u = rr(OP_ADD, A_TA, A_P0, A_T0);
         20:  u = rr(OP_SUB, A_T0, A_P4, A_P7);
         21:  u = rk(OP_FMUL, A_T0, A_T0, BS_DT);
         22:  u = rr(OP_ADD, A_TB, A_P1, A_T0);
         23:  u = rr(OP_SUB, A_T0, A_P5, A_P8);
         24:  u = rk(OP_FMUL, A_T0, A_T0, BS_DT);
         25:  u = rr(OP_ADD, A_TC, A_P2, A_T0);
         26:  u = rr(OP_SUB, A_T0, A_TB, A_TC);
         27:  u = rk(OP_FMUL, A_T0, A_T0, BS_DT);
         28:  u = rr(OP_ADD, A_T0, A_TA, A_T0);
         29:  u = rk(OP_ADD, A_P0, A_T0, BS_QA);
         30:  u = rk(OP_ADD, A_P1, A_TB, BS_ZERO);
         31:  u = rk(OP_ADD, A_P2, A_TC, BS_ZERO);
         32:  u = rr(OP_SUB, A_T0, A_P4, A_P5);
         33:  u = rk(OP_FMUL, A_T0, A_T0, BS_DT);
         34:  u = rr(OP_ADD, A_P3, A_P3, A_T0);
         35:  u = rk(OP_ADD, A_P4, A_P4, BS_QR);
         36:  u = rr(OP_SUB, A_T0, A_P7, A_P8);
         37:  u = rk(OP_FMUL, A_T0, A_T0, BS_DT);
         38:  u = rr(OP_ADD, A_P6, A_P6, A_T0);
         39:  u = rk(OP_ADD, A_P8, A_P8, BS_QB);
         // Innovation and its covariance.
         40:  u = rr(OP_SUB, A_Y1, A_ZA, A_X0);
         41:  u = rr(OP_SUB, A_Y2, A_ZR, A_X1);
         42:  u = rk(OP_ADD, A_S11, A_P0, BS_RA);
         43:  u = rk(OP_ADD, A_S22, A_P4, BS_RR);
         44:  u = rr(OP_PSET, A_T0, A_S11, A_S22);
         45:  u = rr(OP_PSUB, A_T0, A_P1, A_P3);
         46:  u = rr(OP_DET, A_T0, A_T0, A_T0);
         // Gains, each a two-product numerator over the determinant.
         47:  u = rr(OP_PSET, A_T0, A_P0, A_S22);
         48:  u = rr(OP_PSUB, A_T0, A_P1, A_P3);
         49:  u = rr(OP_DIV, A_K11, A_T0, A_T0);
         50:  u = rr(OP_PSET, A_T0, A_P1, A_S11);
         51:  u = rr(OP_PSUB, A_T0, A_P0, A_P1);
         52:  u = rr(OP_DIV, A_K12, A_T0, A_T0);
         53:  u = rr(OP_PSET, A_T0, A_P3, A_S22);
         54:  u = rr(OP_PSUB, A_T0, A_P4, A_P3);
         55:  u = rr(OP_DIV, A_K21, A_T0, A_T0);
         56:  u = rr(OP_PSET, A_T0, A_P4, A_S11);
         57:  u = rr(OP_PSUB, A_T0, A_P3, A_P1);
         58:  u = rr(OP_DIV, A_K22, A_T0, A_T0);
         59:  u = rr(OP_PSET, A_T0, A_P6, A_S22);
         60:  u = rr(OP_PSUB, A_T0, A_P7, A_P3);
         61:  u = rr(OP_DIV, A_K31, A_T0, A_T0);
         62:  u = rr(OP_PSET, A_T0, A_P7, A_S11);
         63:  u = rr(OP_PSUB, A_T0, A_P6, A_P1);
         64:  u = rr(OP_DIV, A_K32, A_T0, A_T0);
         // State correction.
         65:  u = rr(OP_FMUL, A_T0, A_K11, A_Y1);
         66:  u = rr(OP_ADD, A_X0, A_X0, A_T0);
         67:  u = rr(OP_FMUL, A_T0, A_K12, A_Y2);
         68:  u = rr(OP_ADD, A_X0, A_X0, A_T0);
         69:  u = rr(OP_FMUL, A_T0, A_K21, A_Y1);
         70:  u = rr(OP_ADD, A_X1, A_X1, A_T0);
         71:  u = rr(OP_FMUL, A_T0, A_K22, A_Y2);
         72:  u = rr(OP_ADD, A_X1, A_X1, A_T0);
         73:  u = rr(OP_FMUL, A_T0, A_K31, A_Y1);
         74:  u = rr(OP_ADD, A_X2, A_X2, A_T0);
         75:  u = rr(OP_FMUL, A_T0, A_K32, A_Y2);
         76:  u = rr(OP_ADD, A_X2, A_X2, A_T0);
         // Covariance correction from the predicted values.
         77:  u = rk(OP_MOV, A_T1, A_T1, BS_ONE);
         78:  u = rr(OP_SUB, A_M11, A_T1, A_K11);
         79:  u = rr(OP_SUB, A_M22, A_T1, A_K22);
         80:  u = rr(OP_FMUL, A_T0, A_P0, A_M11);
         81:  u = rr(OP_FMUL, A_T1, A_P3, A_K12);
         82:  u = rr(OP_SUB, A_Q11, A_T0, A_T1);
         83:  u = rr(OP_FMUL, A_T0, A_P1, A_M11);
         84:  u = rr(OP_FMUL, A_T1, A_P4, A_K12);
         85:  u = rr(OP_SUB, A_Q12, A_T0, A_T1);
         86:  u = rr(OP_FMUL, A_T0, A_P2, A_M11);
         87:  u = rr(OP_FMUL, A_T1, A_P5, A_K12);
         88:  u = rr(OP_SUB, A_Q13, A_T0, A_T1);
         89:  u = rr(OP_FMUL, A_T0, A_P3, A_M22);
         90:  u = rr(OP_FMUL, A_T1, A_P0, A_K21);
         91:  u = rr(OP_SUB, A_Q21, A_T0, A_T1);
         92:  u = rr(OP_FMUL, A_T0, A_P4, A_M22);
         93:  u = rr(OP_FMUL, A_T1, A_P1, A_K21);
         94:  u = rr(OP_SUB, A_Q22, A_T0, A_T1);
         95:  u = rr(OP_FMUL, A_T0, A_P5, A_M22);
         96:  u = rr(OP_FMUL, A_T1, A_P2, A_K21);
         97:  u = rr(OP_SUB, A_Q23, A_T0, A_T1);
         98:  u = rr(OP_FMUL, A_T0, A_P3, A_K32);
         99:  u = rr(OP_SUB, A_T0, A_P6, A_T0);
         100: u = rr(OP_FMUL, A_T1, A_P0, A_K31);
         101: u = rr(OP_SUB, A_Q31, A_T0, A_T1);
         102: u = rr(OP_FMUL, A_T0, A_P4, A_K32);
         103: u = rr(OP_SUB, A_T0, A_P7, A_T0);
         104: u = rr(OP_FMUL, A_T1, A_P1, A_K31);
         105: u = rr(OP_SUB, A_Q32, A_T0, A_T1);
         106: u = rr(OP_FMUL, A_T0, A_P5, A_K32);
         107: u = rr(OP_SUB, A_T0, A_P8, A_T0);
         108: u = rr(OP_FMUL, A_T1, A_P2, A_K31);
         109: u = rr(OP_SUB, A_Q33, A_T0, A_T1);
         110: u = rk(OP_ADD, A_P0, A_Q11, BS_ZERO);
         111: u = rk(OP_ADD, A_P1, A_Q12, BS_ZERO);
         112: u = rk(OP_ADD, A_P2, A_Q13, BS_ZERO);
         113: u = rk(OP_ADD, A_P3, A_Q21, BS_ZERO);
         114: u = rk(OP_ADD, A_P4, A_Q22, BS_ZERO);
         115: u = rk(OP_ADD, A_P5, A_Q23, BS_ZERO);
         116: u = rk(OP_ADD, A_P6, A_Q31, BS_ZERO);
         117: u = rk(OP_ADD, A_P7, A_Q32, BS_ZERO);
         118: u = rk(OP_ADD, A_P8, A_Q33, BS_ZERO);
         default: u = uo(OP_DONE, A_X0, A_X0, BS_ZERO, A_X0);
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/arbkf_ram.sv =====
// Generic scratch RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module arbkf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]              rdata_a,
   output logic [WIDTH-1:0]              rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// ===== rtl/arbkf_alu.sv =====
// Shared arithmetic unit: registered multiplier and adder, rounding, saturation,
// and the double-width accumulator for determinant and gain numerators. Uses arbkf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arbkf_alu (
   input  wire logic                   clock,
   input  wire arbkf_pkg::alu_ctrl_type ctrl,
   input  wire arbkf_pkg::word_type     a,
   input  wire arbkf_pkg::word_type     b,
   output arbkf_pkg::word_type          wdata,
   output logic                        sat,
   output arbkf_pkg::wide_type          acc,
   output arbkf_pkg::wide_type          det,
   output logic                        acc_zero
);
   import arbkf_pkg::*;

   localparam logic [2*WORD_BITS-1:0] HALF    = (2*WORD_BITS)'(1) << (FRAC_BITS - 1);
   localparam logic [2*WORD_BITS-1:0] POS_LIM = ((2*WORD_BITS)'(1) << (WORD_BITS - 1)) - 1;
   localparam logic [2*WORD_BITS-1:0] NEG_LIM = (2*WORD_BITS)'(1) << (WORD_BITS - 1);
   localparam logic signed [WORD_BITS:0] SUM_MAX = (WORD_BITS+1)'(POS_LIM);
   localparam logic signed [WORD_BITS:0] SUM_MIN = -SUM_MAX - 1;

   prod_type                    prod_ff, prod_in;
   logic signed [WORD_BITS:0]   sum_ff, sum_in;
   wide_type                    acc_ff, acc_in;
   wide_type                    det_ff, det_in;
   logic [2*WORD_BITS-1:0]      mag, rnd, lim;
   logic                        neg;

   always_comb begin
      prod_in = prod_type'(a) * prod_type'(b);
      case (ctrl.op)
         OP_SUB:  sum_in = (WORD_BITS+1)'(a) - (WORD_BITS+1)'(b);
         OP_MOV:  sum_in = (WORD_BITS+1)'(b);
         default: sum_in = (WORD_BITS+1)'(a) + (WORD_BITS+1)'(b);
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      det_in = det_ff;
      if (ctrl.wr_en) begin
         case (ctrl.op)
            OP_PSET: acc_in = wide_type'(prod_ff);
            OP_PSUB: acc_in = acc_ff - wide_type'(prod_ff);
            OP_DET:  det_in = acc_ff;
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec_en) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
      acc_ff <= acc_in;
      det_ff <= det_in;
   end

   // Products round to nearest on the magnitude, ties away from zero; all results saturate.
   always_comb begin
      neg   = prod_ff[2*WORD_BITS-1];
      mag   = neg ? 0 - prod_ff : prod_ff;
      rnd   = (mag + HALF) >> FRAC_BITS;
      lim   = neg ? NEG_LIM : POS_LIM;
      wdata = '0;
      sat   = 1'b0;
      case (ctrl.op)
         OP_FMUL: begin
            if (rnd > lim) begin
               sat   = 1'b1;
               wdata = neg ? word_type'(0 - lim) : word_type'(lim);
            end else begin
               wdata = neg ? word_type'(0 - rnd) : word_type'(rnd);
            end
         end
         default: begin
            if (sum_ff > SUM_MAX) begin
               sat   = 1'b1;
               wdata = word_type'(SUM_MAX);
            end else if (sum_ff < SUM_MIN) begin
               sat   = 1'b1;
               wdata = word_type'(SUM_MIN);
            end else begin
               wdata = word_type'(sum_ff);
            end
         end
      endcase
   end

   assign acc      = acc_ff;
   assign det      = det_ff;
   assign acc_zero = (acc_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/arbkf_div.sv =====
// Restoring divider for the gains: rounded quotient of a double-width numerator
// and determinant, one quotient bit per cycle, saturated to a word. Uses arbkf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arbkf_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire arbkf_pkg::wide_type num,
   input  wire arbkf_pkg::wide_type den,
   output arbkf_pkg::div_stat_type  stat,
   output arbkf_pkg::word_type      quot
);
   import arbkf_pkg::*;

   localparam int N_BITS   = WIDE_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(QUOT_BITS + 1);
   localparam logic [QUOT_BITS:0] POS_LIM = ((QUOT_BITS+1)'(1) << (WORD_BITS - 1)) - 1;
   localparam logic [QUOT_BITS:0] NEG_LIM = (QUOT_BITS+1)'(1) << (WORD_BITS - 1);

   logic                  busy_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [WIDE_BITS-1:0]  r_ff, d_ff;
   logic [QUOT_BITS-1:0]  lo_ff, q_ff;
   logic                  neg_ff, ovf_ff;

   logic [WIDE_BITS-1:0]  n_mag, d_mag, hi_ext;
   logic [N_BITS-1:0]     n_sh;
   logic [WIDE_BITS:0]    r2, r2_sub;
   logic                  ge, rnd_up, done;
   logic [QUOT_BITS:0]    qr, lim, val;

   always_comb begin
      n_mag  = num[WIDE_BITS-1] ? 0 - num : num;
      d_mag  = den[WIDE_BITS-1] ? 0 - den : den;
      n_sh   = {n_mag, {FRAC_BITS{1'b0}}};
      hi_ext = WIDE_BITS'(n_sh[N_BITS-1:QUOT_BITS]);
      r2     = {r_ff, lo_ff[QUOT_BITS-1]};
      r2_sub = r2 - {1'b0, d_ff};
      ge     = (r2 >= {1'b0, d_ff});
      done   = busy_ff && (cnt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= (hi_ext >= d_mag) ? '0 : CNT_BITS'(QUOT_BITS);
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff   <= hi_ext;
         lo_ff  <= n_sh[QUOT_BITS-1:0];
         d_ff   <= d_mag;
         q_ff   <= '0;
         neg_ff <= num[WIDE_BITS-1] != den[WIDE_BITS-1];
         ovf_ff <= (hi_ext >= d_mag);
      end else if (busy_ff && (cnt_ff != '0)) begin
         r_ff  <= ge ? r2_sub[WIDE_BITS-1:0] : r2[WIDE_BITS-1:0];
         lo_ff <= {lo_ff[QUOT_BITS-2:0], 1'b0};
         q_ff  <= {q_ff[QUOT_BITS-2:0], ge};
      end
   end

   // Round up when twice the remainder reaches the divisor.
   always_comb begin
      rnd_up    = ({r_ff, 1'b0} >= {1'b0, d_ff});
      qr        = (QUOT_BITS+1)'(q_ff) + (QUOT_BITS+1)'(rnd_up);
      lim       = neg_ff ? NEG_LIM : POS_LIM;
      stat.sat  = ovf_ff || (qr > lim);
      val       = stat.sat ? lim : qr;
      quot      = neg_ff ? word_type'(0 - val) : word_type'(val);
      stat.busy = busy_ff;
      stat.done = done;
   end

endmodule

`default_nettype wire

// ===== rtl/angle_rate_bias_kalman_filter_top.sv =====
// Top level of the three-state angle, rate and bias filter: sequencer, configuration
// registers and result register. Uses arbkf_pkg, arbkf_ram, arbkf_alu and arbkf_div.
`timescale 1ns / 1ps
`default_nettype none
`include "angle_rate_bias_kalman_filter_top_assert.svh"

//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid/req_ready    angle_meas, rate_meas, restart
//  rsp_      out        rsp_valid/rsp_ready    angle_est, rate_est, bias_est, status
//  csr_      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// An item with restart set (or the first item after reset) also runs the reload
// steps; one whose innovation matrix is singular skips the gains and corrections.
// Each of the 107 steps after the reload passes through the read and execute
// states and then the write state of the shared multiplier/adder or the divider.
// Reset is synchronous; the filter state is reloaded by the first item's steps.
// A result waits in its register while a new item is taken; the sequencer stalls
// at the end of an item only while the previous result is still not taken.

module angle_rate_bias_kalman_filter_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire arbkf_pkg::req_type       req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output arbkf_pkg::rsp_type            rsp_payload,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire arbkf_pkg::csr_index_type csr_index,
   input  wire arbkf_pkg::csr_data_type  csr_wdata
);
   import arbkf_pkg::*;

   state_type state_ff, state_in;
   pc_type    pc_ff;
   uop_type   uop;

   // Configuration registers.
   logic [DT_BITS-1:0]    dt_ff;
   logic [NOISE_BITS-1:0] qa_ff, qr_ff, qb_ff, ra_ff, rr_ff;

   // Item state: latched measurements and the flags of this transfer.
   word_type  z1_ff, z2_ff;
   logic      need_init_ff;
   logic      sat_ff, sing_ff;

   // Copies of the three estimates, updated on every write to them.
   word_type  angle_ff, rate_ff, bias_ff;

   logic      rsp_valid_ff;
   rsp_type   rsp_ff;

   logic         ram_we;
   addr_type     ram_waddr;
   word_type     ram_wdata;
   logic [WORD_BITS-1:0] rdata_a, rdata_b;
   word_type     opa, opb;

   alu_ctrl_type alu_ctrl;
   word_type     alu_wdata;
   logic         alu_sat;
   wide_type     acc, det;
   logic         acc_zero;

   logic         div_start;
   div_stat_type div_stat;
   word_type     div_quot;

   logic         req_fire, out_free, step_writes;

   assign uop       = ucode(pc_ff);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   arbkf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (uop.a),
      .raddr_b (uop.b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   // The second operand comes from the scratch memory, a constant, a configuration register or a measurement.
   always_comb begin
      opa = word_type'(rdata_a);
      case (uop.bsel)
         BS_MEM:  opb = word_type'(rdata_b);
         BS_ZERO: opb = '0;
         BS_ONE:  opb = FIX_ONE;
         BS_INIT: opb = FIX_INIT;
         BS_DT:   opb = word_type'(dt_ff);
         BS_QA:   opb = word_type'(qa_ff);
         BS_QR:   opb = word_type'(qr_ff);
         BS_QB:   opb = word_type'(qb_ff);
         BS_RA:   opb = word_type'(ra_ff);
         BS_RR:   opb = word_type'(rr_ff);
         BS_Z1:   opb = z1_ff;
         BS_Z2:   opb = z2_ff;
         default: opb = '0;
      endcase
   end

   arbkf_alu u_alu (
      .clock    (clock),
      .ctrl     (alu_ctrl),
      .a        (opa),
      .b        (opb),
      .wdata    (alu_wdata),
      .sat      (alu_sat),
      .acc      (acc),
      .det      (det),
      .acc_zero (acc_zero)
   );

   arbkf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc),
      .den   (det),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_READ;
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC: begin
            case (uop.op)
               OP_DIV:  state_in = ST_DIV;
               OP_DONE: state_in = ST_OUT;
               default: state_in = ST_WRITE;
            endcase
         end
         ST_WRITE: state_in = ST_READ;
         ST_DIV:   if (div_stat.done) state_in = ST_READ;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      step_writes = (uop.op == OP_MOV) || (uop.op == OP_ADD) ||
                    (uop.op == OP_SUB) || (uop.op == OP_FMUL);
      req_ready        = (state_ff == ST_IDLE);
      alu_ctrl.exec_en = (state_ff == ST_EXEC);
      alu_ctrl.wr_en   = (state_ff == ST_WRITE);
      alu_ctrl.op      = uop.op;
      div_start        = (state_ff == ST_EXEC) && (uop.op == OP_DIV);
      ram_waddr        = uop.dst;
      ram_we           = 1'b0;
      ram_wdata        = alu_wdata;
      case (state_ff)
         ST_WRITE: ram_we = step_writes;
         ST_DIV: begin
            ram_we    = div_stat.done;
            ram_wdata = div_quot;
         end
         default: ram_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         need_init_ff <= 1'b1;
         sat_ff       <= 1'b0;
         sing_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            pc_ff        <= (req_payload.restart || need_init_ff) ? '0 : INIT_LEN;
            need_init_ff <= 1'b0;
            sat_ff       <= 1'b0;
            sing_ff      <= 1'b0;
         end else if (state_ff == ST_WRITE) begin
            if ((uop.op == OP_DET) && acc_zero) begin
               sing_ff <= 1'b1;
               pc_ff   <= DONE_PC;
            end else begin
               pc_ff <= pc_ff + 1'b1;
            end
            if (step_writes && alu_sat) begin
               sat_ff <= 1'b1;
            end
         end else if ((state_ff == ST_DIV) && div_stat.done) begin
            pc_ff <= pc_ff + 1'b1;
            if (div_stat.sat) begin
               sat_ff <= 1'b1;
            end
         end
         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         z1_ff <= req_payload.angle_meas;
         z2_ff <= req_payload.rate_meas;
      end
      if (ram_we) begin
         case (ram_waddr)
            A_X0:    angle_ff <= ram_wdata;
            A_X1:    rate_ff  <= ram_wdata;
            A_X2:    bias_ff  <= ram_wdata;
            default: angle_ff <= angle_ff;
         endcase
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_ff.angle_est <= angle_ff;
         rsp_ff.rate_est  <= rate_ff;
         rsp_ff.bias_est  <= bias_ff;
         rsp_ff.status    <= sat_ff ? STATUS_SATURATED :
                             (sing_ff ? STATUS_SINGULAR : STATUS_OK);
      end
   end

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= DT_BITS'(655);
         qa_ff <= NOISE_BITS'(66);
         qr_ff <= NOISE_BITS'(197);
         qb_ff <= NOISE_BITS'(197);
         ra_ff <= NOISE_BITS'(1966);
         rr_ff <= NOISE_BITS'(1966);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIME_STEP: dt_ff <= csr_wdata[DT_BITS-1:0];
            CSR_ANGLE_QNS: qa_ff <= csr_wdata[NOISE_BITS-1:0];
            CSR_RATE_QNS:  qr_ff <= csr_wdata[NOISE_BITS-1:0];
            CSR_BIAS_QNS:  qb_ff <= csr_wdata[NOISE_BITS-1:0];
            CSR_ANGLE_RNS: ra_ff <= csr_wdata[NOISE_BITS-1:0];
            CSR_RATE_RNS:  rr_ff <= csr_wdata[NOISE_BITS-1:0];
            default:       dt_ff <= dt_ff;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // An accepted transfer always starts the step sequence.
   `AKF_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == ST_READ, "accepted item did not start")
   // The divider only runs while the sequencer waits for it.
   `AKF_ASSERT_NOW(a_div_in_div_state, div_stat.busy, state_ff == ST_DIV, "divider busy outside its step")
   // The step counter never runs past the final step.
   `AKF_ASSERT_NOW(a_pc_bounded, state_ff != ST_IDLE, pc_ff <= DONE_PC, "step counter out of range")
   // A singular determinant leads straight to the final step.
   `AKF_ASSERT_NEXT(a_singular_skips, (state_ff == ST_WRITE) && (uop.op == OP_DET) && acc_zero, pc_ff == DONE_PC, "singular case not skipped")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the angle, rate and bias Kalman filter top level.
// Depends on arbkf_pkg and angle_rate_bias_kalman_filter_top. It checks each result
// against a fixed-point predictor of the filter step or a result set by hand.
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import arbkf_pkg::*;

   typedef logic signed [129:0] wide_t;
   typedef logic [159:0]        mag_t;
   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

   // One row of the directed stimulus. A register row writes csr index and data.
   // An item row sends one transfer and, when typed is set, carries a result
   // that can be read off by hand.
   typedef struct {
      row_kind_t     kind;
      csr_index_type index;
      csr_data_type  data;
      logic [31:0]   angle;
      logic [31:0]   rate;
      logic          restart;
      logic          typed;
      rsp_type       result;
   } row_t;

   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;
   localparam csr_index_type CSR_SPARE_6 = 3'd6;
   localparam csr_index_type CSR_SPARE_7 = 3'd7;
   localparam csr_data_type  NOISE_MAX   = 31'h7fffffff;
   localparam int            ITEM_LATENCY = 600;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = '0;
   csr_data_type  csr_wdata = '0;

   // Filter state and register copy held by the predictor.
   longint   estimate[3];
   longint   covar[9];
   longint   reg_value[6];
   logic     saturated;
   rsp_type  pending_results[$];
   int       failures = 0;
   int       tx_idle_pct = 0;
   int       rx_idle_pct = 0;
   row_t     rows[$];

   always #4 clock = ~clock;

   angle_rate_bias_kalman_filter_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Fixed-point arithmetic. Every clamp to the word range raises the saturation
   // flag of the current step.
   // ---------------------------------------------------------------------------
   function automatic longint clamp_word(longint v);
      if (v > WMAX) begin
         saturated = 1'b1;
         return WMAX;
      end
      if (v < WMIN) begin
         saturated = 1'b1;
         return WMIN;
      end
      return v;
   endfunction

   function automatic longint sat_add(longint a, longint b);
      return clamp_word(a + b);
   endfunction

   function automatic longint sat_sub(longint a, longint b);
      return clamp_word(a - b);
   endfunction

   // A magnitude with its sign goes back to a word; the negative side reaches
   // one step further than the positive one.
   function automatic longint signed_word(logic neg, mag_t m);
      mag_t lim;
      lim = neg ? mag_t'(64'd2147483648) : mag_t'(64'd2147483647);
      if (m > lim) begin
         saturated = 1'b1;
         m = lim;
      end
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   // Q16.16 product, rounded to nearest with ties away from zero.
   function automatic longint fix_mul(longint a, longint b);
      mag_t ma, mb, p;
      ma = (a < 0) ? mag_t'(-a) : mag_t'(a);
      mb = (b < 0) ? mag_t'(-b) : mag_t'(b);
      p = ma * mb + (mag_t'(1) << (FRAC_BITS - 1));
      return signed_word((a < 0) != (b < 0), p >> FRAC_BITS);
   endfunction

   function automatic wide_t exact_prod(longint a, longint b);
      wide_t wa, wb;
      wa = a;
      wb = b;
      return wa * wb;
   endfunction

   // Gain as the rounded quotient of numerator and determinant in Q16.16.
   function automatic longint gain_quot(wide_t num, wide_t den);
      wide_t an, ad;
      mag_t  n, d, q, r;
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      n = mag_t'(an) << FRAC_BITS;
      d = mag_t'(ad);
      q = n / d;
      r = n % d;
      if (2 * r >= d) q = q + 1;
      return signed_word((num < 0) != (den < 0), q);
   endfunction

   function automatic longint reg_word(int i);
      return (reg_value[i] > WMAX) ? WMAX : reg_value[i];
   endfunction

   function automatic void load_initial();
      for (int i = 0; i < 3; i++) estimate[i] = 0;
      for (int i = 0; i < 9; i++) covar[i] = 0;
      covar[0] = longint'(1000) <<< FRAC_BITS;
      covar[4] = covar[0];
      covar[8] = covar[0];
   endfunction

   function automatic void write_reg_copy(csr_index_type idx, csr_data_type data);
      if (idx == CSR_TIME_STEP) reg_value[0] = longint'(data[DT_BITS-1:0]);
      else if (int'(idx) <= int'(CSR_RATE_RNS)) reg_value[idx] = longint'(data);
   endfunction

   // One filter step: predict, innovation, gains, correction. Returns the result
   // that the block is to report for this transfer.
   function automatic rsp_type filter_step(req_type item);
      longint x[3], p[9], q[9];
      longint dt, z1, z2, a, b, c, y1, y2, s11, s12, s21, s22;
      longint k11, k12, k21, k22, k31, k32, m11, m22;
      wide_t  det;
      logic   singular;
      rsp_type r;
      if (item.restart) load_initial();
      saturated = 1'b0;
      x = estimate;
      p = covar;
      z1 = longint'(item.angle_meas);
      z2 = longint'(item.rate_meas);
      dt = reg_word(0);

      x[0] = sat_add(x[0], fix_mul(sat_sub(x[1], x[2]), dt));
      a = sat_add(p[0], fix_mul(sat_sub(p[3], p[6]), dt));
      b = sat_add(p[1], fix_mul(sat_sub(p[4], p[7]), dt));
      c = sat_add(p[2], fix_mul(sat_sub(p[5], p[8]), dt));
      p[0] = sat_add(sat_add(a, fix_mul(sat_sub(b, c), dt)), reg_word(1));
      p[1] = b;
      p[2] = c;
      p[3] = sat_add(p[3], fix_mul(sat_sub(p[4], p[5]), dt));
      p[4] = sat_add(p[4], reg_word(2));
      p[6] = sat_add(p[6], fix_mul(sat_sub(p[7], p[8]), dt));
      p[8] = sat_add(p[8], reg_word(3));

      y1 = sat_sub(z1, x[0]);
      y2 = sat_sub(z2, x[1]);
      s11 = sat_add(p[0], reg_word(4));
      s12 = p[1];
      s21 = p[3];
      s22 = sat_add(p[4], reg_word(5));
      det = exact_prod(s11, s22) - exact_prod(s12, s21);
      singular = (det == 0);

      if (!singular) begin
         k11 = gain_quot(exact_prod(p[0], s22) - exact_prod(p[1], s21), det);
         k12 = gain_quot(exact_prod(p[1], s11) - exact_prod(p[0], s12), det);
         k21 = gain_quot(exact_prod(p[3], s22) - exact_prod(p[4], s21), det);
         k22 = gain_quot(exact_prod(p[4], s11) - exact_prod(p[3], s12), det);
         k31 = gain_quot(exact_prod(p[6], s22) - exact_prod(p[7], s21), det);
         k32 = gain_quot(exact_prod(p[7], s11) - exact_prod(p[6], s12), det);

         x[0] = sat_add(sat_add(x[0], fix_mul(k11, y1)), fix_mul(k12, y2));
         x[1] = sat_add(sat_add(x[1], fix_mul(k21, y1)), fix_mul(k22, y2));
         x[2] = sat_add(sat_add(x[2], fix_mul(k31, y1)), fix_mul(k32, y2));

         // The covariance correction reads only the predicted values.
         m11 = sat_sub(longint'(1) <<< FRAC_BITS, k11);
         m22 = sat_sub(longint'(1) <<< FRAC_BITS, k22);
         q[0] = sat_sub(fix_mul(p[0], m11), fix_mul(p[3], k12));
         q[1] = sat_sub(fix_mul(p[1], m11), fix_mul(p[4], k12));
         q[2] = sat_sub(fix_mul(p[2], m11), fix_mul(p[5], k12));
         q[3] = sat_sub(fix_mul(p[3], m22), fix_mul(p[0], k21));
         q[4] = sat_sub(fix_mul(p[4], m22), fix_mul(p[1], k21));
         q[5] = sat_sub(fix_mul(p[5], m22), fix_mul(p[2], k21));
         q[6] = sat_sub(sat_sub(p[6], fix_mul(p[3], k32)), fix_mul(p[0], k31));
         q[7] = sat_sub(sat_sub(p[7], fix_mul(p[4], k32)), fix_mul(p[1], k31));
         q[8] = sat_sub(sat_sub(p[8], fix_mul(p[5], k32)), fix_mul(p[2], k31));
         p = q;
      end
      estimate = x;
      covar = p;

      r.angle_est = x[0][31:0];
      r.rate_est  = x[1][31:0];
      r.bias_est  = x[2][31:0];
      r.status    = saturated ? STATUS_SATURATED : (singular ? STATUS_SINGULAR : STATUS_OK);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Result side. Ready toggles at random per the current receiver idle rate,
   // and every accepted transfer is compared with the oldest expectation.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with no expectation waiting");
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.angle_est !== want.angle_est) begin
                  $error("angle_est expected %0d actual %0d", want.angle_est,
                         rsp_payload.angle_est);
                  failures++;
               end
               if (rsp_payload.rate_est !== want.rate_est) begin
                  $error("rate_est expected %0d actual %0d", want.rate_est,
                         rsp_payload.rate_est);
                  failures++;
               end
               if (rsp_payload.bias_est !== want.bias_est) begin
                  $error("bias_est expected %0d actual %0d", want.bias_est,
                         rsp_payload.bias_est);
                  failures++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status,
                         rsp_payload.status);
                  failures++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Request side helpers.
   // ---------------------------------------------------------------------------

   // Sends one item. Valid may be left high from the previous transfer, so an
   // idle gap lowers it first and the raise always happens on a later edge.
   task automatic send_item(req_type item, logic typed, rsp_type typed_result);
      int gap;
      rsp_type predicted;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predicted = filter_step(item);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // Register writes happen only with the block idle: valid is dropped and every
   // expected result has come back first.
   task automatic write_reg(csr_index_type idx, csr_data_type data);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      write_reg_copy(idx, data);
   endtask

   function automatic row_t item_row(logic [31:0] angle, logic [31:0] rate, logic restart);
      row_t r;
      r = '{kind: ROW_ITEM, index: '0, data: '0, angle: angle, rate: rate,
            restart: restart, typed: 1'b0, result: '0};
      return r;
   endfunction

   function automatic row_t reg_row(csr_index_type idx, csr_data_type data);
      row_t r;
      r = item_row('0, '0, 1'b0);
      r.kind  = ROW_REG;
      r.index = idx;
      r.data  = data;
      return r;
   endfunction

   // Zero measurements on a fresh state keep every estimate at zero.
   function automatic row_t zero_row();
      row_t r;
      r = item_row('0, '0, 1'b1);
      r.typed  = 1'b1;
      r.result = '{angle_est: '0, rate_est: '0, bias_est: '0, status: STATUS_OK};
      return r;
   endfunction

   function automatic csr_data_type random_noise();
      case ($urandom_range(9))
         0:       return '0;
         1:       return NOISE_MAX;
         2:       return csr_data_type'($urandom);
         default: return csr_data_type'($urandom_range(4000));
      endcase
   endfunction

   function automatic csr_data_type random_step();
      case ($urandom_range(5))
         0:       return '0;
         1:       return csr_data_type'(16'hffff);
         2:       return csr_data_type'($urandom_range(65535));
         default: return csr_data_type'($urandom_range(2000));
      endcase
   endfunction

   task automatic random_setting();
      write_reg(CSR_TIME_STEP, random_step());
      write_reg(CSR_ANGLE_QNS, random_noise());
      write_reg(CSR_RATE_QNS, random_noise());
      write_reg(CSR_BIAS_QNS, random_noise());
      write_reg(CSR_ANGLE_RNS, random_noise());
      write_reg(CSR_RATE_RNS, random_noise());
   endtask

   // Mostly a slowly moving target with a measured rate near it; a tenth of the
   // items are raw noise across all 32 bits, and now and then a restart.
   function automatic req_type random_item(ref longint angle_track);
      req_type item;
      longint rate;
      rate = longint'($urandom_range(2 * 65536 * 8)) - 65536 * 8;
      angle_track = angle_track + (rate >>> 9);
      if (angle_track > 64'sd100000000 || angle_track < -64'sd100000000) angle_track = 0;
      if ($urandom_range(9) == 0) begin
         item.angle_meas = $urandom;
         item.rate_meas  = $urandom;
      end else begin
         item.angle_meas = 32'(angle_track + longint'($urandom_range(4096)) - 2048);
         item.rate_meas  = 32'(rate + longint'($urandom_range(1024)) - 512);
      end
      item.restart = ($urandom_range(49) == 0);
      return item;
   endfunction

   // ---------------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------------
   initial begin
      req_type item;
      longint  angle_track;
      int      tx_pct[3];
      int      rx_pct[3];
      reg_value[0] = 655;
      reg_value[1] = 66;
      reg_value[2] = 197;
      reg_value[3] = 197;
      reg_value[4] = 1966;
      reg_value[5] = 1966;
      load_initial();
      angle_track = 0;
      tx_pct = '{21, 66, 0};
      rx_pct = '{66, 21, 0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: reset defaults, field extremes, the unused register
      // indexes, a zero-noise setting that drives the innovation singular, and
      // the largest settings that push the arithmetic into saturation.
      rows.push_back(zero_row());
      rows.push_back(item_row(32'h7fffffff, 32'h7fffffff, 1'b0));
      rows.push_back(item_row(32'h80000000, 32'h80000000, 1'b0));
      rows.push_back(item_row(32'hffffffff, 32'h00000001, 1'b1));
      rows.push_back(reg_row(CSR_SPARE_6, NOISE_MAX));
      rows.push_back(reg_row(CSR_SPARE_7, '0));
      rows.push_back(reg_row(CSR_TIME_STEP, '0));
      rows.push_back(reg_row(CSR_ANGLE_QNS, '0));
      rows.push_back(reg_row(CSR_RATE_QNS, '0));
      rows.push_back(reg_row(CSR_BIAS_QNS, '0));
      rows.push_back(reg_row(CSR_ANGLE_RNS, '0));
      rows.push_back(reg_row(CSR_RATE_RNS, '0));
      rows.push_back(zero_row());
      rows.push_back(item_row(32'h00010000, 32'h00010000, 1'b0));
      rows.push_back(item_row(32'h00020000, 32'hffff0000, 1'b0));
      rows.push_back(reg_row(CSR_TIME_STEP, csr_data_type'(16'hffff)));
      rows.push_back(reg_row(CSR_ANGLE_QNS, NOISE_MAX));
      rows.push_back(reg_row(CSR_RATE_QNS, NOISE_MAX));
      rows.push_back(reg_row(CSR_BIAS_QNS, NOISE_MAX));
      rows.push_back(reg_row(CSR_ANGLE_RNS, NOISE_MAX));
      rows.push_back(reg_row(CSR_RATE_RNS, NOISE_MAX));
      rows.push_back(item_row(32'h7fffffff, 32'h80000000, 1'b1));
      rows.push_back(item_row(32'h80000000, 32'h7fffffff, 1'b0));
      rows.push_back(item_row(32'h12345678, 32'hedcba987, 1'b0));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_REG) begin
            write_reg(rows[i].index, rows[i].data);
         end else begin
            item = '{angle_meas: rows[i].angle, rate_meas: rows[i].rate,
                     restart: rows[i].restart};
            send_item(item, rows[i].typed, rows[i].result);
         end
      end

      // Random part in three idling phases, each with its own register setting
      // and a mid-phase change. Each change waits for the block to drain.
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = tx_pct[phase];
         rx_idle_pct = rx_pct[phase];
         random_setting();
         for (int n = 0; n < 376; n++) begin
            if (n == 188) random_setting();
            send_item(random_item(angle_track), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (ITEM_LATENCY) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog, several times the slowest correct run.
   initial begin
      #40ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
